>>> rtl/cmaf_pkg.sv
package cmaf_pkg;

   localparam int BUFFER_COUNT_DEF = 32;
   localparam int ID_W             = 29;
   localparam int DLC_W            = 4;
   localparam int OP_W             = 3;
   localparam int IDX_IN_W         = 8;
   localparam int NUM_W            = 6;
   localparam int STATUS_W         = 2;
   localparam int DRV_W            = 2;

   localparam logic [ID_W-1:0] STD_ID_MASK = ID_W'(32'h0000_07FF);

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [DRV_W-1:0]    drv_type;

   localparam op_type OP_CONFIGURE = 3'd0;
   localparam op_type OP_RELEASE   = 3'd1;
   localparam op_type OP_SET_DLC   = 3'd2;
   localparam op_type OP_READ      = 3'd3;
   localparam op_type OP_RECEIVE   = 3'd4;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_DRIVER = 2'd1;
   localparam status_type STATUS_BAD_INDEX = 2'd2;

   localparam drv_type DRIVER_OFF = 2'd0;

   // One message buffer as stored in the table
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [ID_W-1:0]  mask;
      logic [DLC_W-1:0] dlc;
      logic             ext;
      logic             fd;
      logic             rcv;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      op_type              op;
      logic [IDX_IN_W-1:0] idx;
      logic [ID_W-1:0]     id;
      logic [ID_W-1:0]     mask;
      logic                ext;
      logic                fd;
      logic                trm;
      logic [DLC_W-1:0]    dlc;
   } request_type;

   typedef struct packed {
      status_type       status;
      logic             matched;
      logic [NUM_W-1:0] number;
      logic [ID_W-1:0]  ident;
      logic [DLC_W-1:0] dlc;
      logic             last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MODIFY,
      ST_RESP,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic rd_index;
      logic rd_first;
      logic write_back;
      logic emit_single;
      logic scan_step;
      logic emit_final;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic direct;
      logic receive;
      logic match;
      logic scan_end;
      logic hold_valid;
      logic slot_free;
   } dp_status_type;

endpackage

>>> rtl/cmaf_if.sv
interface cmaf_req_if import cmaf_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [IDX_IN_W-1:0] buffer_index;
   logic [ID_W-1:0]     identifier;
   logic [ID_W-1:0]     accept_mask;
   logic                extended_format;
   logic                fast_data;
   logic                transmit_dir;
   logic [DLC_W-1:0]    dlc_in;

   modport source (
      output valid, operation, buffer_index, identifier, accept_mask,
             extended_format, fast_data, transmit_dir, dlc_in,
      input  ready
   );
   modport sink (
      input  valid, operation, buffer_index, identifier, accept_mask,
             extended_format, fast_data, transmit_dir, dlc_in,
      output ready
   );
endinterface

interface cmaf_rsp_if import cmaf_pkg::*; ();
   logic             valid;
   logic             ready;
   status_type       status;
   logic             matched;
   logic [NUM_W-1:0] buffer_number;
   logic [ID_W-1:0]  identifier_out;
   logic [DLC_W-1:0] dlc_out;
   logic             last;

   modport source (
      output valid, status, matched, buffer_number, identifier_out, dlc_out, last,
      input  ready
   );
   modport sink (
      input  valid, status, matched, buffer_number, identifier_out, dlc_out, last,
      output ready
   );
endinterface

>>> rtl/can_mailbox_acceptance_filter.sv
// Sequence: a buffer operation reads its table entry, writes it back, then loads its
//   result; an error or an unused code loads its result straight after the check; a
//   receive scans one buffer per cycle unless a second match waits for the output.
// A new request is taken only in idle, once the last has loaded its result; a receive
//   lasts its scan through the table's single read port; output stalls lengthen both.
// Reset (synchronous, active high): driver state off, controller idle, no result pending,
//   all table entries read as zero until written (per-entry valid bits).
module can_mailbox_acceptance_filter import cmaf_pkg::*; #(
   parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cmaf_req_if.sink    req_chan,
   cmaf_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  drv_type     csr_wr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   result_type    rsp_result;
   logic          rsp_valid;
   logic          req_ready;

   // Controller: sequences one transaction at a time through check, table access,
   // scan and result hand-off.
   cmaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Datapath: request capture, driver state, buffer table, match logic and
   // the result register that parts the input side from the output side.
   cmaf_dpath #(
      .BUFFER_COUNT (BUFFER_COUNT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_operation       (req_chan.operation),
      .req_buffer_index    (req_chan.buffer_index),
      .req_identifier      (req_chan.identifier),
      .req_accept_mask     (req_chan.accept_mask),
      .req_extended_format (req_chan.extended_format),
      .req_fast_data       (req_chan.fast_data),
      .req_transmit_dir    (req_chan.transmit_dir),
      .req_dlc_in          (req_chan.dlc_in),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_valid),
      .rsp_result          (rsp_result),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status)
   );

   // Accept a new transaction while an earlier result still waits at the output.
   assign req_chan.ready = req_ready;

   // Drive the result channel straight from the result register.
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.status         = rsp_result.status;
   assign rsp_chan.matched        = rsp_result.matched;
   assign rsp_chan.buffer_number  = rsp_result.number;
   assign rsp_chan.identifier_out = rsp_result.ident;
   assign rsp_chan.dlc_out        = rsp_result.dlc;
   assign rsp_chan.last           = rsp_result.last;

endmodule

>>> rtl/cmaf_ram.sv
module cmaf_ram import cmaf_pkg::*; #(
   parameter int  WIDTH  = ENTRY_W,
   parameter int  DEPTH  = BUFFER_COUNT_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cmaf_ctrl.sv
module cmaf_ctrl import cmaf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dp_status.direct) begin
               state_in = ST_RESP;
            end else if (dp_status.receive) begin
               dp_cmd.rd_first = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               dp_cmd.rd_index = 1'b1;
               state_in        = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            dp_cmd.write_back = 1'b1;
            state_in          = ST_RESP;
         end
         ST_RESP: begin
            if (dp_status.slot_free) begin
               dp_cmd.emit_single = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // stall only when a second match has to push out the held one
            if (!(dp_status.match && dp_status.hold_valid && !dp_status.slot_free)) begin
               dp_cmd.scan_step = 1'b1;
               if (dp_status.scan_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (dp_status.slot_free) begin
               dp_cmd.emit_final = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/cmaf_dpath.sv
module cmaf_dpath import cmaf_pkg::*; #(
   parameter int  BUFFER_COUNT = BUFFER_COUNT_DEF,
   localparam int IDX_W        = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  drv_type             csr_wr_data,
   input  op_type              req_operation,
   input  logic [IDX_IN_W-1:0] req_buffer_index,
   input  logic [ID_W-1:0]     req_identifier,
   input  logic [ID_W-1:0]     req_accept_mask,
   input  logic                req_extended_format,
   input  logic                req_fast_data,
   input  logic                req_transmit_dir,
   input  logic [DLC_W-1:0]    req_dlc_in,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output result_type          rsp_result,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status
);

   localparam int                  CNT_W     = IDX_W + 1;
   localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(BUFFER_COUNT - 1);
   localparam logic [IDX_IN_W:0]   COUNT_LIM = (IDX_IN_W + 1)'(BUFFER_COUNT);

   drv_type                driver_ff, driver_in;
   request_type            req_ff, req_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [NUM_W-1:0]       hold_num_ff, hold_num_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic [BUFFER_COUNT-1:0] valid_ff, valid_in;
   logic                   rd_vld_ff, rd_vld_in;

   logic [ID_W-1:0]  cut;
   logic             op_is_buf;
   status_type       err_status;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_word;
   logic [ENTRY_W-1:0] ram_q;
   entry_type        q;
   logic             match;
   logic             scan_end;
   logic             slot_free;
   logic             load;
   logic [NUM_W-1:0] scan_num;

   // cut identifier and mask to the frame format at capture
   assign cut = req_extended_format ? '1 : STD_ID_MASK;

   always_comb begin
      req_in = req_ff;
      if (dp_cmd.capture) begin
         req_in.op   = req_operation;
         req_in.idx  = req_buffer_index;
         req_in.id   = req_identifier & cut;
         req_in.mask = req_accept_mask & cut;
         req_in.ext  = req_extended_format;
         req_in.fd   = req_fast_data;
         req_in.trm  = req_transmit_dir;
         req_in.dlc  = req_dlc_in;
      end
   end

   assign driver_in = csr_wr_en ? csr_wr_data : driver_ff;

   always_comb begin
      op_is_buf  = (req_ff.op <= OP_READ);
      err_status = STATUS_OK;
      if (op_is_buf && (driver_ff == DRIVER_OFF)) begin
         err_status = STATUS_NO_DRIVER;
      end else if (op_is_buf && !({1'b0, req_ff.idx} < COUNT_LIM)) begin
         err_status = STATUS_BAD_INDEX;
      end
   end

   // table read side
   assign q        = rd_vld_ff ? entry_type'(ram_q) : '0;
   assign match    = q.rcv && (q.ext == req_ff.ext) && (((q.id ^ req_ff.id) & q.mask) == '0);
   assign scan_end = (scan_ff == LAST_IDX);
   assign scan_num = NUM_W'({1'b0, scan_ff} + CNT_W'(1));

   assign rd_en   = dp_cmd.rd_index || dp_cmd.rd_first || (dp_cmd.scan_step && !scan_end);
   assign rd_addr = dp_cmd.rd_first  ? '0 :
                    dp_cmd.scan_step ? IDX_W'(scan_ff + IDX_W'(1)) :
                                       req_ff.idx[IDX_W-1:0];

   assign rd_vld_in = rd_en ? valid_ff[rd_addr] : rd_vld_ff;
   assign scan_in   = dp_cmd.rd_first ? '0 :
                      dp_cmd.scan_step ? IDX_W'(scan_ff + IDX_W'(1)) : scan_ff;

   // table write side
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_ff.idx[IDX_W-1:0];
      wr_word = q;
      if (dp_cmd.scan_step) begin
         wr_en       = match;
         wr_addr     = scan_ff;
         wr_word.id  = req_ff.id;
         wr_word.dlc = req_ff.dlc;
      end else if (dp_cmd.write_back) begin
         case (req_ff.op)
            OP_CONFIGURE: begin
               wr_en        = 1'b1;
               wr_word.id   = req_ff.id;
               wr_word.mask = req_ff.mask;
               wr_word.ext  = req_ff.ext;
               wr_word.fd   = req_ff.fd;
               wr_word.rcv  = !req_ff.trm;
            end
            OP_RELEASE: begin
               // mask and direction survive a release
               wr_en       = 1'b1;
               wr_word.id  = '0;
               wr_word.dlc = '0;
               wr_word.ext = 1'b0;
               wr_word.fd  = 1'b0;
            end
            OP_SET_DLC: begin
               wr_en       = 1'b1;
               wr_word.dlc = req_ff.dlc;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // one match is held back so the final one can carry last
   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_num_in = hold_num_ff;
      if (dp_cmd.rd_first || dp_cmd.emit_final) begin
         hold_vld_in = 1'b0;
      end else if (dp_cmd.scan_step && match) begin
         hold_vld_in = 1'b1;
         hold_num_in = scan_num;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      load   = 1'b0;
      rsp_in = rsp_ff;
      if (dp_cmd.emit_single) begin
         load           = 1'b1;
         rsp_in         = '0;
         rsp_in.status  = err_status;
         rsp_in.last    = 1'b1;
         if ((req_ff.op == OP_READ) && (err_status == STATUS_OK)) begin
            rsp_in.ident = q.id;
            rsp_in.dlc   = q.dlc;
         end
      end else if ((dp_cmd.scan_step && match && hold_vld_ff) ||
                   (dp_cmd.emit_final && hold_vld_ff)) begin
         load           = 1'b1;
         rsp_in.status  = STATUS_OK;
         rsp_in.matched = 1'b1;
         rsp_in.number  = hold_num_ff;
         rsp_in.ident   = req_ff.id;
         rsp_in.dlc     = req_ff.dlc;
         rsp_in.last    = dp_cmd.emit_final;
      end else if (dp_cmd.emit_final) begin
         load        = 1'b1;
         rsp_in      = '0;
         rsp_in.last = 1'b1;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         driver_ff    <= DRIVER_OFF;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         driver_ff    <= driver_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      hold_num_ff <= hold_num_in;
      rsp_ff      <= rsp_in;
   end

   cmaf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BUFFER_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_word)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign dp_status.direct     = (err_status != STATUS_OK) || (req_ff.op > OP_RECEIVE);
   assign dp_status.receive    = (req_ff.op == OP_RECEIVE);
   assign dp_status.match      = match;
   assign dp_status.scan_end   = scan_end;
   assign dp_status.hold_valid = hold_vld_ff;
   assign dp_status.slot_free  = slot_free;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load && rsp_valid_ff |-> rsp_ready)
      else $error("result register overwritten while stalled");

   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.matched |-> rsp_ff.status == STATUS_OK)
      else $error("matched result carries an error status");

   a_nomatch_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.matched |-> rsp_ff.number == '0)
      else $error("unmatched result carries a buffer number");

   a_hold_rx: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> req_ff.op == OP_RECEIVE)
      else $error("held match outside a receive");

endmodule
